// ----- rtl/fixed_block_pool_allocator_defines.svh -----
// assertion macros for the fixed block pool allocator
// used by fbpa_core, the rtl file that carries concurrent checks; no other dependencies
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH

// check that is held off while reset is asserted
`define FBPA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("fbpa check failed");

// check that also holds during reset
`define FBPA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("fbpa check failed");

`else

`define FBPA_ASSERT(label, clk, rst_n, prop)
`define FBPA_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ----- rtl/fbpa_pkg.sv -----
// shared types, constants and helpers of the fixed block pool allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fbpa_pkg;

  localparam int MaxBlocks = 1024;
  localparam int IdxW      = $clog2(MaxBlocks);
  localparam int CntW      = IdxW + 1;
  localparam int SlotW     = 17;
  localparam int OffW      = 26;
  localparam int CmdW      = 2;
  localparam int StatusW   = 2;
  localparam int CfgIdxW   = 2;

  // commands
  localparam logic [CmdW-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CmdW-1:0] CMD_FREE   = 2'd1;
  localparam logic [CmdW-1:0] CMD_CREATE = 2'd2;

  // result status
  localparam logic [StatusW-1:0] ST_OK     = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY  = 2'd1;
  localparam logic [StatusW-1:0] ST_REJECT = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_BLOCK_BYTES   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BLOCKS_IN_USE = 2'd1;

  localparam logic [SlotW-1:0] BlockBytesRst  = 17'd64;
  localparam logic [CntW-1:0]  BlocksInUseRst = 11'd1024;
  localparam logic [SlotW-1:0] SlotMin        = 17'd8;
  localparam logic [SlotW-1:0] SlotMax        = 17'd65536;
  localparam logic [CntW-1:0]  PoolMax        = CntW'(MaxBlocks);

  typedef struct packed {
    logic [SlotW-1:0] block_bytes;
    logic [CntW-1:0]  blocks_in_use;
  } cfg_regs_t;

  typedef struct packed {
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    logic [IdxW-1:0] wr_data;
  } ram_req_t;

  // clamp to [8, 65536] and round up to a multiple of 8
  function automatic logic [SlotW-1:0] slot_size(input logic [SlotW-1:0] sz);
    logic [SlotW:0] sum;
    logic [SlotW-1:0] res;
    sum = {1'b0, sz} + (SlotW+1)'(7);
    if (sz < SlotMin) begin
      res = SlotMin;
    end else if (sz > SlotMax) begin
      res = SlotMax;
    end else begin
      res = {sum[SlotW-1:3], 3'b000};
    end
    return res;
  endfunction

  function automatic logic [CntW-1:0] pool_clamp(input logic [CntW-1:0] n);
    return (n > PoolMax) ? PoolMax : n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/fbpa_link_ram.sv -----
// single-port-write, single-port-read link memory with registered read data
// generic, no package dependency
`timescale 1ns / 1ps
`default_nettype none

module fbpa_link_ram #(
  parameter int Depth = 1024,
  parameter int Width = 10,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [Width-1:0] rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fbpa_core.sv -----
// free list control: list head, never-used counter, free count and result registers
// depends on fbpa_pkg and the assertion macros header
`timescale 1ns / 1ps
`default_nettype none

`include "fixed_block_pool_allocator_defines.svh"

module fbpa_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      accept_i,
  input  wire logic [fbpa_pkg::CmdW-1:0] cmd_i,
  input  wire logic [fbpa_pkg::IdxW-1:0] block_index_i,
  input  wire fbpa_pkg::cfg_regs_t       cfg_i,
  output fbpa_pkg::ram_req_t             ram_req_o,
  input  wire logic [fbpa_pkg::IdxW-1:0] ram_rd_data_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic [fbpa_pkg::StatusW-1:0]   status_o,
  output logic [fbpa_pkg::IdxW-1:0]      granted_index_o,
  output logic [fbpa_pkg::OffW-1:0]      byte_offset_o,
  output logic [fbpa_pkg::CntW-1:0]      blocks_free_o
);
  import fbpa_pkg::*;

  logic             busy_q, done_q;
  logic [CmdW-1:0]  cmd_q;
  logic [IdxW-1:0]  idx_q;
  logic [IdxW-1:0]  head_q, head_d;
  logic             nonempty_q, nonempty_d;
  logic [CntW-1:0]  fresh_q, fresh_d;
  logic [CntW-1:0]  free_q, free_d;
  logic [CntW-1:0]  pool_q, pool_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [StatusW-1:0] status_d;
  logic [IdxW-1:0]  grant_d;
  logic             push;
  logic [CntW:0]    avail_sum;
  logic [OffW:0]    prod;

  // head is read at accept; its link comes back for the pop in the following cycle
  assign ram_req_o.rd_en   = accept_i;
  assign ram_req_o.rd_addr = head_q;
  assign ram_req_o.wr_en   = push;
  assign ram_req_o.wr_addr = idx_q;
  assign ram_req_o.wr_data = head_q;

  always_comb begin
    head_d     = head_q;
    nonempty_d = nonempty_q;
    fresh_d    = fresh_q;
    free_d     = free_q;
    pool_d     = pool_q;
    slot_d     = slot_q;
    status_d   = ST_OK;
    grant_d    = '0;
    push       = 1'b0;
    avail_sum  = '0;
    if (busy_q) begin
      case (cmd_q)
        CMD_ALLOC: begin
          if (free_q == '0) begin
            status_d = ST_EMPTY;
          end else if (nonempty_q) begin
            grant_d    = head_q;
            head_d     = ram_rd_data_i;
            free_d     = free_q - CntW'(1);
            // recycled length is free - (pool - fresh)
            avail_sum  = {1'b0, free_d} + {1'b0, fresh_q};
            nonempty_d = avail_sum > {1'b0, pool_q};
          end else begin
            grant_d = fresh_q[IdxW-1:0];
            fresh_d = fresh_q + CntW'(1);
            free_d  = free_q - CntW'(1);
          end
        end
        CMD_FREE: begin
          if ({1'b0, idx_q} >= pool_q || free_q >= pool_q) begin
            status_d = ST_REJECT;
          end else begin
            push       = 1'b1;
            head_d     = idx_q;
            nonempty_d = 1'b1;
            free_d     = free_q + CntW'(1);
          end
        end
        CMD_CREATE: begin
          pool_d     = pool_clamp(cfg_i.blocks_in_use);
          slot_d     = slot_size(cfg_i.block_bytes);
          head_d     = '0;
          nonempty_d = 1'b0;
          fresh_d    = '0;
          free_d     = pool_clamp(cfg_i.blocks_in_use);
        end
        default: begin
        end
      endcase
    end
  end

  assign prod = (OffW+1)'(grant_d) * (OffW+1)'(slot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      done_q     <= 1'b0;
      head_q     <= '0;
      nonempty_q <= 1'b0;
      fresh_q    <= '0;
      free_q     <= pool_clamp(BlocksInUseRst);
      pool_q     <= pool_clamp(BlocksInUseRst);
      slot_q     <= slot_size(BlockBytesRst);
    end else begin
      busy_q     <= accept_i;
      done_q     <= busy_q;
      head_q     <= head_d;
      nonempty_q <= nonempty_d;
      fresh_q    <= fresh_d;
      free_q     <= free_d;
      pool_q     <= pool_d;
      slot_q     <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      cmd_q <= cmd_i;
      idx_q <= block_index_i;
    end
    if (busy_q) begin
      status_o        <= status_d;
      granted_index_o <= grant_d;
      byte_offset_o   <= (cmd_q == CMD_ALLOC && status_d == ST_OK) ? prod[OffW-1:0] : '0;
      blocks_free_o   <= free_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

  `FBPA_ASSERT(a_accept_busy, clk_i, rst_ni, accept_i |=> busy_q)
  `FBPA_ASSERT(a_done_after_busy, clk_i, rst_ni, done_q |-> $past(busy_q))
  `FBPA_ASSERT(a_free_bound, clk_i, rst_ni, free_q <= pool_q && fresh_q <= pool_q)
  `FBPA_ASSERT(a_list_flag, clk_i, rst_ni,
               nonempty_q == (({1'b0, free_q} + {1'b0, fresh_q}) > {1'b0, pool_q}))

endmodule

`default_nettype wire

// ----- rtl/fixed_block_pool_allocator.sv -----
// done_o strobes each result after an accept, registered through busy_q then done_q
// start_i is not taken while busy_o is high, so no request enters before the last leaves busy
// busy_o is high in the cycle after each accept; results cannot be held off
// reset: asynchronous, active low; the pool comes up built from the reset register
// values (64-byte blocks, 1024 blocks); the link memory needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_pool_allocator (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [fbpa_pkg::CmdW-1:0]    cmd_i,
  input  wire logic [fbpa_pkg::IdxW-1:0]    block_index_i,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [fbpa_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [fbpa_pkg::SlotW-1:0]   cfg_data_i,
  output logic                              done_o,
  output logic [fbpa_pkg::StatusW-1:0]      status_o,
  output logic [fbpa_pkg::IdxW-1:0]         granted_index_o,
  output logic [fbpa_pkg::OffW-1:0]         byte_offset_o,
  output logic [fbpa_pkg::CntW-1:0]         blocks_free_o
);
  import fbpa_pkg::*;

  cfg_regs_t       cfg_q;
  ram_req_t        ram_req;
  logic [IdxW-1:0] ram_rd_data;
  logic            accept;

  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;

  // registers take effect at the next create
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_bytes   <= BlockBytesRst;
      cfg_q.blocks_in_use <= BlocksInUseRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_BLOCK_BYTES:   cfg_q.block_bytes   <= cfg_data_i;
        REG_BLOCKS_IN_USE: cfg_q.blocks_in_use <= cfg_data_i[CntW-1:0];
        default: begin
        end
      endcase
    end
  end

  fbpa_link_ram #(
    .Depth(MaxBlocks),
    .Width(IdxW)
  ) u_link_ram (
    .clk_i    (clk_i),
    .rd_en_i  (ram_req.rd_en),
    .rd_addr_i(ram_req.rd_addr),
    .rd_data_o(ram_rd_data),
    .wr_en_i  (ram_req.wr_en),
    .wr_addr_i(ram_req.wr_addr),
    .wr_data_i(ram_req.wr_data)
  );

  fbpa_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .cmd_i          (cmd_i),
    .block_index_i  (block_index_i),
    .cfg_i          (cfg_q),
    .ram_req_o      (ram_req),
    .ram_rd_data_i  (ram_rd_data),
    .busy_o         (busy_o),
    .done_o         (done_o),
    .status_o       (status_o),
    .granted_index_o(granted_index_o),
    .byte_offset_o  (byte_offset_o),
    .blocks_free_o  (blocks_free_o)
  );

endmodule

`default_nettype wire
